// File: rtl/core/gcd_lcm_unit_assert.svh
// Assertion macros for the GCD and LCM unit.
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GLU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit: same-cycle check failed");
`define GLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit: next-cycle check failed");
`else
`define GLU_ASSERT_SAME(label, clk, rst, ante, cons)
`define GLU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/glu_pkg.sv
// Shared constants, types and divider interface structs for the GCD and LCM unit.
package glu_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int LCM_WIDTH     = 2 * OPERAND_WIDTH;
  localparam int COUNT_WIDTH   = $clog2(OPERAND_WIDTH + 1);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;

  typedef struct packed {
    logic     go;
    operand_t dividend;
    operand_t divisor;
  } div_req_t;

  typedef struct packed {
    logic     done;
    operand_t quotient;
    operand_t remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_MOD,
    ST_QLAUNCH,
    ST_QWAIT,
    ST_MUL
  } state_t;

endpackage

// File: rtl/core/glu_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module glu_div
  import glu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                   busy;
  logic                   done;
  logic [COUNT_WIDTH-1:0] count;
  operand_t               rem;
  operand_t               quo;
  operand_t               div;

  logic [OPERAND_WIDTH:0] rem_shift;
  logic [OPERAND_WIDTH:0] rem_diff;
  logic                   fits;
  operand_t               rem_next;
  operand_t               quo_next;

  always_comb begin
    rem_shift = {rem, quo[OPERAND_WIDTH-1]};
    rem_diff  = rem_shift - {1'b0, div};
    fits      = rem_shift >= {1'b0, div};
    rem_next  = fits ? rem_diff[OPERAND_WIDTH-1:0] : rem_shift[OPERAND_WIDTH-1:0];
    quo_next  = {quo[OPERAND_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy  <= 1'b1;
        count <= COUNT_WIDTH'(OPERAND_WIDTH);
      end else if (busy) begin
        count <= count - COUNT_WIDTH'(1);
        if (count == COUNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      quo <= req.dividend;
      rem <= '0;
      div <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: rtl/core/gcd_lcm_unit.sv
// Top level of the GCD and LCM unit: Euclid sequencer over one shared divider.
//
//   Channel   Handshake          Signals
//   request   start, busy        first_operand, second_operand
//   result    done (one cycle)   gcd_value, lcm_value, zero_operand_error
//
// Each Euclid remainder step and the final quotient use the shared divider.
// A request with a zero operand gives its result in the next cycle.
// Reset is synchronous and returns the sequencer to idle.
// The receiver cannot stall: the result is shown for exactly one cycle.
`include "gcd_lcm_unit_assert.svh"

module gcd_lcm_unit
  import glu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPERAND_WIDTH-1:0] first_operand,
  input  logic [OPERAND_WIDTH-1:0] second_operand,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] gcd_value,
  output logic [LCM_WIDTH-1:0]     lcm_value,
  output logic                     zero_operand_error
);

  state_t   state;
  state_t   state_next;
  logic     done_next;
  operand_t opa;
  operand_t opb;
  operand_t big;
  operand_t small_val;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     zero_in;

  assign zero_in = (first_operand == '0) || (second_operand == '0);

  glu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !zero_in) state_next = ST_LAUNCH;
      end
      ST_LAUNCH: state_next = ST_MOD;
      ST_MOD: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.remainder == '0) ? ST_QLAUNCH : ST_LAUNCH;
        end
      end
      ST_QLAUNCH: state_next = ST_QWAIT;
      ST_QWAIT: begin
        if (div_rsp.done) state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_req.go       = 1'b0;
    div_req.dividend = big;
    div_req.divisor  = small_val;
    done_next        = 1'b0;
    unique case (state)
      ST_IDLE:    done_next = start && zero_in;
      ST_LAUNCH:  div_req.go = 1'b1;
      ST_QLAUNCH: begin
        div_req.go       = 1'b1;
        div_req.dividend = opa;
        div_req.divisor  = big;
      end
      ST_MUL:     done_next = 1'b1;
      default:    done_next = 1'b0;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          opa <= first_operand;
          opb <= second_operand;
          if (first_operand < second_operand) begin
            big       <= second_operand;
            small_val <= first_operand;
          end else begin
            big       <= first_operand;
            small_val <= second_operand;
          end
          if (zero_in) begin
            gcd_value          <= '0;
            lcm_value          <= '0;
            zero_operand_error <= 1'b1;
          end
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          big       <= small_val;
          small_val <= div_rsp.remainder;
        end
      end
      ST_MUL: begin
        gcd_value          <= big;
        lcm_value          <= LCM_WIDTH'(div_rsp.quotient) * LCM_WIDTH'(opb);
        zero_operand_error <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  `GLU_ASSERT_SAME(a_error_gives_zero, clk, rst, done && zero_operand_error, gcd_value == '0 && lcm_value == '0)
  `GLU_ASSERT_SAME(a_gcd_nonzero, clk, rst, done && !zero_operand_error, gcd_value != '0)
  `GLU_ASSERT_NEXT(a_request_taken, clk, rst, start && !busy, busy || done)
  `GLU_ASSERT_SAME(a_no_launch_idle, clk, rst, div_req.go, busy)

endmodule

// File: verif/gcd_lcm_unit_tb.sv
// Self-checking testbench for gcd_lcm_unit with a built-in GCD and LCM predictor.
module gcd_lcm_unit_tb;
  import glu_pkg::*;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam operand_t MAX_OPERAND = '1;

  typedef struct {
    operand_t               gcd;
    logic [LCM_WIDTH-1:0]   lcm;
    logic                   zero_err;
  } gcd_lcm_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  operand_t               first_operand = '0;
  operand_t               second_operand = '0;
  logic                   done;
  operand_t               gcd_value;
  logic [LCM_WIDTH-1:0]   lcm_value;
  logic                   zero_operand_error;

  gcd_lcm_result_t pending_results[$];
  int unsigned     failures = 0;
  int unsigned     cycle_count = 0;
  bit              gaps_enabled = 1'b1;

  gcd_lcm_unit dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .first_operand      (first_operand),
    .second_operand     (second_operand),
    .done               (done),
    .gcd_value          (gcd_value),
    .lcm_value          (lcm_value),
    .zero_operand_error (zero_operand_error)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("gcd_lcm_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic gcd_lcm_result_t predict_gcd_lcm(operand_t a, operand_t b);
    gcd_lcm_result_t      r;
    operand_t             big;
    operand_t             sml;
    operand_t             rem;
    logic [LCM_WIDTH-1:0] cofactor;
    r.gcd = '0;
    r.lcm = '0;
    r.zero_err = 1'b1;
    if (a != '0 && b != '0) begin
      big = (a < b) ? b : a;
      sml = (a < b) ? a : b;
      while (sml != '0) begin
        rem = big % sml;
        big = sml;
        sml = rem;
      end
      cofactor = LCM_WIDTH'(a / big);
      r.gcd = big;
      r.lcm = cofactor * LCM_WIDTH'(b);
      r.zero_err = 1'b0;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!gaps_enabled || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_request(input operand_t a, input operand_t b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    first_operand <= a;
    second_operand <= b;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(predict_gcd_lcm(a, b));
  endtask

  task automatic pick_request(output operand_t a, output operand_t b);
    int       kind;
    int       n;
    operand_t g;
    operand_t f0;
    operand_t f1;
    operand_t t;
    kind = $urandom_range(0, 99);
    a = $urandom;
    b = $urandom;
    if (kind < 5) begin
      case ($urandom_range(0, 2))
        0: a = '0;
        1: b = '0;
        default: begin
          a = '0;
          b = '0;
        end
      endcase
    end else if (kind < 35) begin
      if (a == '0) a = 1;
      if (b == '0) b = 1;
    end else if (kind < 60) begin
      g = $urandom_range(1, 65535) >> $urandom_range(0, 15);
      if (g == '0) g = 1;
      a = g * $urandom_range(1, MAX_OPERAND / g);
      b = g * $urandom_range(1, MAX_OPERAND / g);
    end else if (kind < 75) begin
      a = a >> $urandom_range(0, 31);
      b = b >> $urandom_range(0, 31);
      if (a == '0) a = 1;
      if (b == '0) b = 1;
    end else if (kind < 85) begin
      b = $urandom_range(1, 65535);
      a = b * $urandom_range(1, MAX_OPERAND / b);
      if ($urandom_range(0, 1)) {a, b} = {b, a};
    end else if (kind < 90) begin
      if (a == '0) a = 1;
      b = a;
    end else if (kind < 95) begin
      n = $urandom_range(1, 45);
      f0 = 1;
      f1 = 1;
      repeat (n) begin
        t = f0 + f1;
        f0 = f1;
        f1 = t;
      end
      a = f1;
      b = f0;
      if ($urandom_range(0, 1)) {a, b} = {b, a};
    end else begin
      a = operand_t'(1) << $urandom_range(0, 31);
      b = (b | operand_t'(1)) << $urandom_range(0, 31);
    end
  endtask

  always @(posedge clk) begin
    gcd_lcm_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: gcd %0d lcm %0d err %0b", gcd_value, lcm_value,
                   zero_operand_error);
      end else begin
        want = pending_results.pop_front();
        if (gcd_value !== want.gcd || lcm_value !== want.lcm ||
            zero_operand_error !== want.zero_err) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected gcd %0d lcm %0d err %0b, got gcd %0d lcm %0d err %0b",
                     want.gcd, want.lcm, want.zero_err, gcd_value, lcm_value,
                     zero_operand_error);
        end
      end
    end
  end

  task automatic test_zero_operands();
    gaps_enabled = 1'b1;
    send_request('0, '0);
    send_request('0, MAX_OPERAND);
    send_request(MAX_OPERAND, '0);
    send_request('0, 1);
    send_request(1, '0);
  endtask

  task automatic test_extreme_operands();
    gaps_enabled = 1'b0;
    send_request(1, 1);
    send_request(MAX_OPERAND, MAX_OPERAND);
    send_request(MAX_OPERAND, 1);
    send_request(1, MAX_OPERAND);
    send_request(MAX_OPERAND, MAX_OPERAND - 1);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'h8000_0000, 1);
    send_request(MAX_OPERAND, 32'h8000_0000);
    send_request(6, 4);
    send_request(4, 6);
    send_request(32'd2971215073, 32'd1836311903);
    send_request(32'd4294967291, 32'd4294967279);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_mixed_requests(input int count);
    operand_t a;
    operand_t b;
    gaps_enabled = 1'b1;
    repeat (count) begin
      pick_request(a, b);
      send_request(a, b);
    end
  endtask

  task automatic test_back_to_back_requests(input int count);
    operand_t a;
    operand_t b;
    gaps_enabled = 1'b0;
    repeat (count) begin
      pick_request(a, b);
      send_request(a, b);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_zero_operands();
    test_extreme_operands();
    test_mixed_requests(900);
    test_back_to_back_requests(350);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("gcd_lcm_unit_tb OK");
    end else begin
      $display("gcd_lcm_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
